>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define UPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset.
`define UPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/upb_pkg.sv
// Shared widths, register indices and constants of the upscale blit unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package upb_pkg;

  localparam int PIX_W  = 16;
  localparam int ADDR_W = 24;
  localparam int RGBA_W = 32;
  localparam int REG_W  = 12;
  localparam int IDX_W  = 3;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  // configuration register indices
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BUF_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BUF_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_STRIDE = 3'd4;
  localparam logic [IDX_W-1:0] REG_VFLIP      = 3'd5;
  localparam logic [IDX_W-1:0] REG_HMIRROR    = 3'd6;
  localparam logic [IDX_W-1:0] REG_PIX_FORMAT = 3'd7;

endpackage

`default_nettype wire

>>> sv/integer_upscale_blit_unit.sv
// Integer nearest-neighbour upscaler: source pixels in, framebuffer writes out.
// Depends on upb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One source pixel word is taken while in_stall_o is low. A pixel inside the
// source frame then runs through a short sequencer: factor pick, centring
// offset, block origin, clipping against the buffer and one row-base multiply,
// after which the clipped block is streamed one write word per cycle while
// out_stall_i is low, row by row, from a single output register. A pixel
// gives w*h words, w*h being the surviving part of its factor-by-factor block
// (at most 64 at factor 8). A pixel outside the frame, or whose block is
// fully clipped, gives no words. Row addresses are stepped by row_stride
// through one adder; x and y walk the clipped box, so last_of_run falls on
// the bottom-right surviving write. frame_start zeroes the raster position
// before its pixel is placed. Configuration may be written at any time but
// is meant to change only while the unit is idle.
module integer_upscale_blit_unit #(
  parameter int COORD_BITS = 12,
  parameter int MAX_FACTOR = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [upb_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [upb_pkg::REG_W-1:0]  cfg_data_i,
  // source pixels
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [upb_pkg::PIX_W-1:0]  pixel_value_i,
  input  wire logic                       frame_start_i,
  // framebuffer writes
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [upb_pkg::ADDR_W-1:0]      dest_address_o,
  output logic [upb_pkg::RGBA_W-1:0]      rgba_color_o,
  output logic                            last_of_run_o
);
  import upb_pkg::*;

  localparam int CW = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
  localparam int SW = 18; // signed working width for buffer coordinates

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FAC  = 3'd1;
  localparam logic [2:0] ST_OFF  = 3'd2;
  localparam logic [2:0] ST_ORG  = 3'd3;
  localparam logic [2:0] ST_CLIP = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  // configuration registers
  logic [REG_W-1:0] src_w_q, src_h_q, buf_w_q, buf_h_q, stride_q;
  logic             vflip_q, hmirror_q, gray_q;

  // sequencer and raster position
  logic [2:0]            state_q, state_d;
  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;

  // per-pixel working registers
  logic [23:0]          rgb_q, rgb_d;
  logic [REG_W-1:0]     px_q, px_d, py_q, py_d;
  logic [1:0]           fac_q, fac_d;
  logic signed [SW-1:0] off_x_q, off_x_d, off_y_q, off_y_d;
  logic signed [SW-1:0] dx0_q, dx0_d, dy0_q, dy0_d;
  logic [REG_W-1:0]     x_lo_q, x_lo_d, x_hi_q, x_hi_d;
  logic [REG_W-1:0]     y_lo_q, y_lo_d, y_hi_q, y_hi_d;
  logic [REG_W-1:0]     x_q, x_d, y_q, y_d;
  logic [ADDR_W-1:0]    row_base_q, row_base_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [23:0]       out_rgb_q, out_rgb_d;
  logic              out_last_q, out_last_d;

  // ---- accept-time terms ----
  logic [COORD_BITS-1:0] base_col, base_row, col_inc;
  logic [CW-1:0]         col_ext, row_ext;
  logic                  in_frame, col_wrap;
  logic [REG_W-1:0]      col12, row12;
  logic [23:0]           rgb_conv;

  always_comb begin
    base_col = frame_start_i ? '0 : col_q;
    base_row = frame_start_i ? '0 : row_q;
    col_ext  = CW'(base_col);
    row_ext  = CW'(base_row);
    in_frame = (col_ext < CW'(src_w_q)) && (row_ext < CW'(src_h_q));
    col12    = col_ext[REG_W-1:0];
    row12    = row_ext[REG_W-1:0];
    col_inc  = base_col + COORD_BITS'(1);
    col_wrap = (CW'(col_inc) >= CW'(src_w_q)) || (col_inc == '0);
    if (gray_q) begin
      rgb_conv = {3{pixel_value_i[7:0]}};
    end else begin
      rgb_conv = {pixel_value_i[4:0],   pixel_value_i[4:2],
                  pixel_value_i[10:5],  pixel_value_i[10:9],
                  pixel_value_i[15:11], pixel_value_i[15:13]};
    end
  end

  // ---- factor pick: largest power of two, up to 8 and MAX_FACTOR, that fits both ways ----
  logic [1:0] fac_pick;
  always_comb begin
    fac_pick = 2'd0;
    for (int k = 1; k <= 3; k++) begin
      if (((1 << k) <= MAX_FACTOR) &&
          ((16'(src_w_q) << k) <= 16'(buf_w_q)) &&
          ((16'(src_h_q) << k) <= 16'(buf_h_q))) begin
        fac_pick = 2'(k);
      end
    end
  end

  // ---- centring offset, rounded toward zero ----
  logic [SW-1:0]        sw_sh, sh_sh;
  logic signed [SW-1:0] diff_x, diff_y, adj_x, adj_y;
  always_comb begin
    sw_sh  = SW'(src_w_q) << fac_q;
    sh_sh  = SW'(src_h_q) << fac_q;
    diff_x = $signed(SW'(buf_w_q)) - $signed(sw_sh);
    diff_y = $signed(SW'(buf_h_q)) - $signed(sh_sh);
    adj_x  = diff_x + $signed({{(SW-1){1'b0}}, diff_x[SW-1]});
    adj_y  = diff_y + $signed({{(SW-1){1'b0}}, diff_y[SW-1]});
  end

  // ---- clip box ----
  logic [3:0]           fm1;
  logic signed [SW-1:0] dx_end, dy_end, bw_m1, bh_m1;
  logic signed [SW-1:0] xl_s, xh_s, yl_s, yh_s;
  logic                 box_empty;
  always_comb begin
    fm1       = 4'((4'd1 << fac_q) - 4'd1);
    dx_end    = dx0_q + $signed(SW'(fm1));
    dy_end    = dy0_q + $signed(SW'(fm1));
    bw_m1     = $signed(SW'(buf_w_q)) - $signed(SW'(1));
    bh_m1     = $signed(SW'(buf_h_q)) - $signed(SW'(1));
    xl_s      = dx0_q[SW-1] ? '0 : dx0_q;
    yl_s      = dy0_q[SW-1] ? '0 : dy0_q;
    xh_s      = (dx_end < bw_m1) ? dx_end : bw_m1;
    yh_s      = (dy_end < bh_m1) ? dy_end : bh_m1;
    box_empty = (xl_s > xh_s) || (yl_s > yh_s);
  end

  logic [ADDR_W-1:0] row_prod;
  assign row_prod = {12'b0, y_lo_q} * {12'b0, stride_q};

  logic load, is_last, x_end;
  assign load    = !out_valid_q || !out_stall_i;
  assign x_end   = (x_q == x_hi_q);
  assign is_last = x_end && (y_q == y_hi_q);

  // ---- sequencer ----
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    rgb_d       = rgb_q;
    px_d        = px_q;
    py_d        = py_q;
    fac_d       = fac_q;
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    dx0_d       = dx0_q;
    dy0_d       = dy0_q;
    x_lo_d      = x_lo_q;
    x_hi_d      = x_hi_q;
    y_lo_d      = y_lo_q;
    y_hi_d      = y_hi_q;
    x_d         = x_q;
    y_d         = y_q;
    row_base_d  = row_base_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_rgb_d   = out_rgb_q;
    out_last_d  = out_last_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // position advance, row saturates
          if (col_wrap) begin
            col_d = '0;
            row_d = (base_row != '1) ? base_row + COORD_BITS'(1) : base_row;
          end else begin
            col_d = col_inc;
            row_d = base_row;
          end
          rgb_d = rgb_conv;
          px_d  = hmirror_q ? src_w_q - REG_W'(1) - col12 : col12;
          py_d  = vflip_q   ? src_h_q - REG_W'(1) - row12 : row12;
          if (in_frame) state_d = ST_FAC;
        end
      end
      ST_FAC: begin
        fac_d   = fac_pick;
        state_d = ST_OFF;
      end
      ST_OFF: begin
        off_x_d = adj_x >>> 1;
        off_y_d = adj_y >>> 1;
        state_d = ST_ORG;
      end
      ST_ORG: begin
        dx0_d   = off_x_q + $signed(SW'(px_q) << fac_q);
        dy0_d   = off_y_q + $signed(SW'(py_q) << fac_q);
        state_d = ST_CLIP;
      end
      ST_CLIP: begin
        x_lo_d  = xl_s[REG_W-1:0];
        x_hi_d  = xh_s[REG_W-1:0];
        y_lo_d  = yl_s[REG_W-1:0];
        y_hi_d  = yh_s[REG_W-1:0];
        state_d = box_empty ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        row_base_d = row_prod;
        x_d        = x_lo_q;
        y_d        = y_lo_q;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_addr_d  = row_base_q + ADDR_W'(x_q);
          out_rgb_d   = rgb_q;
          out_last_d  = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end else if (x_end) begin
            x_d        = x_lo_q;
            y_d        = y_q + REG_W'(1);
            row_base_d = row_base_q + ADDR_W'(stride_q);
          end else begin
            x_d = x_q + REG_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      src_w_q     <= 12'd320;
      src_h_q     <= 12'd240;
      buf_w_q     <= 12'd640;
      buf_h_q     <= 12'd480;
      stride_q    <= 12'd640;
      vflip_q     <= 1'b0;
      hmirror_q   <= 1'b0;
      gray_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SRC_WIDTH:  src_w_q   <= cfg_data_i;
          REG_SRC_HEIGHT: src_h_q   <= cfg_data_i;
          REG_BUF_WIDTH:  buf_w_q   <= cfg_data_i;
          REG_BUF_HEIGHT: buf_h_q   <= cfg_data_i;
          REG_ROW_STRIDE: stride_q  <= cfg_data_i;
          REG_VFLIP:      vflip_q   <= cfg_data_i[0];
          REG_HMIRROR:    hmirror_q <= cfg_data_i[0];
          REG_PIX_FORMAT: gray_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    rgb_q      <= rgb_d;
    px_q       <= px_d;
    py_q       <= py_d;
    fac_q      <= fac_d;
    off_x_q    <= off_x_d;
    off_y_q    <= off_y_d;
    dx0_q      <= dx0_d;
    dy0_q      <= dy0_d;
    x_lo_q     <= x_lo_d;
    x_hi_q     <= x_hi_d;
    y_lo_q     <= y_lo_d;
    y_hi_q     <= y_hi_d;
    x_q        <= x_d;
    y_q        <= y_d;
    row_base_q <= row_base_d;
    out_addr_q <= out_addr_d;
    out_rgb_q  <= out_rgb_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign dest_address_o = out_addr_q;
  assign rgba_color_o   = {OPAQUE_ALPHA, out_rgb_q};
  assign last_of_run_o  = out_last_q;

endmodule

`default_nettype wire

>>> sv/upb_checker.sv
// Port-level checks for integer_upscale_blit_unit, bound to the top level.
// Depends on upb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module upb_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [upb_pkg::ADDR_W-1:0] dest_address_o,
  input wire logic [upb_pkg::RGBA_W-1:0] rgba_color_o,
  input wire logic                      last_of_run_o
);
  import upb_pkg::*;

  // a held write word keeps its payload
  `UPB_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(dest_address_o) && $stable(rgba_color_o) && $stable(last_of_run_o), "stalled write word changed")

  // the unit only goes busy on a taken pixel
  `UPB_ASSERT(a_busy_from_take, $rose(in_stall_o) |-> $past(in_valid_i), "unit busy without a taken pixel")

  // words are only produced while a pixel is being worked on
  `UPB_ASSERT(a_word_from_busy, $rose(out_valid_o) |-> $past(in_stall_o), "write word appeared while idle")

  // a taken word without the last flag means more of the run follows
  `UPB_ASSERT(a_run_continues, out_valid_o && !out_stall_i && !last_of_run_o |-> in_stall_o, "run ended without last flag")

  // every colour is opaque
  `UPB_ASSERT(a_opaque, out_valid_o |-> rgba_color_o[RGBA_W-1:RGBA_W-8] == OPAQUE_ALPHA, "alpha not opaque")

endmodule

bind integer_upscale_blit_unit upb_checker u_upb_checker (.*);

`default_nettype wire
